// ===== design/differential_drive_dual_pid_core_defines.svh =====
// ============================================================================
// Differential drive dual PID core: assertion macros
// Shared concurrent assertion forms used by the core and by its loop and mixer submodules.
// ============================================================================
`ifndef DIFFERENTIAL_DRIVE_DUAL_PID_CORE_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_DUAL_PID_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DDPID_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddpid assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define DDPID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddpid assertion failed");

`endif

// ===== design/ddpid_pkg.sv =====
// ============================================================================
// Differential drive dual PID package
// Shared types and fixed constants for the dual PID drive controller.
// ============================================================================
package ddpid_pkg;

    localparam int GAIN_W    = 16;
    localparam int IDX_W     = 3;
    localparam int DRIVE_W   = 8;
    localparam int DRIVE_MAX = 100;

    // The loop divisor of twelve is split into four times three.
    localparam int DIV_CONST     = 12;
    localparam int DIV_POW2_BITS = 2;
    localparam int QUOT_W        = 9;
    localparam int RECIP_MUL     = 171;
    localparam int RECIP_SHIFT   = 9;
    localparam int RECIP_PROD_W  = QUOT_W + 8;

    localparam int NUM_STAGES = 9;
    localparam int LANE_RIGHT = 0;
    localparam int LANE_LEFT  = 1;
    localparam int NUM_LANES  = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_LAT_P,
        REG_LAT_I,
        REG_LAT_D,
        REG_TURN_P,
        REG_TURN_I,
        REG_TURN_D
    } t_reg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
    } t_gains;

    typedef struct packed {
        logic ld_in;
        logic ld_avg;
        logic ld_err;
        logic ld_state;
        logic ld_prod;
        logic ld_acc;
        logic ld_mix;
        logic ld_mag;
        logic ld_out;
    } t_pipe_ctl;

endpackage

// ===== design/ddpid_err.sv =====
// ============================================================================
// Differential drive dual PID error front end
// Registers the encoder transaction, forms the average position and the
// front wheel difference, and produces the lateral and turn errors.
// ============================================================================
module ddpid_err import ddpid_pkg::*; #(
    parameter int POS_WIDTH = 24
) (
    input  logic                        i_clk,
    input  t_pipe_ctl                   i_ctl,
    input  logic signed [POS_WIDTH-1:0] i_right_front_pos,
    input  logic signed [POS_WIDTH-1:0] i_left_front_pos,
    input  logic signed [POS_WIDTH-1:0] i_left_back_pos,
    input  logic signed [POS_WIDTH-1:0] i_right_back_pos,
    input  logic signed [POS_WIDTH-1:0] i_target_distance,
    input  logic signed [POS_WIDTH-1:0] i_target_turn,
    output logic signed [POS_WIDTH:0]   o_lat_err,
    output logic signed [POS_WIDTH:0]   o_turn_err
);

    localparam int ERR_W  = POS_WIDTH + 1;
    localparam int SUM4_W = POS_WIDTH + 2;

    logic signed [POS_WIDTH-1:0] r_rf, r_lf, r_lb, r_rb, r_td, r_tt;
    logic signed [POS_WIDTH-1:0] r_avg, r_td1, r_tt1;
    logic signed [ERR_W-1:0]     r_diff;
    logic signed [ERR_W-1:0]     r_lat_err, r_turn_err;

    logic signed [SUM4_W-1:0] w_sum4, w_bias, w_biased;
    logic signed [SUM4_W-1:0] w_turn_full;
    logic signed [ERR_W-1:0]  w_turn_sat;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_in) begin
            r_rf <= i_right_front_pos;
            r_lf <= i_left_front_pos;
            r_lb <= i_left_back_pos;
            r_rb <= i_right_back_pos;
            r_td <= i_target_distance;
            r_tt <= i_target_turn;
        end
    end

    // A negative sum is biased by three so that the shift truncates toward zero.
    assign w_sum4   = SUM4_W'(r_rf) + SUM4_W'(r_lf) + SUM4_W'(r_lb) + SUM4_W'(r_rb);
    assign w_bias   = {POS_WIDTH'(0), w_sum4[SUM4_W-1], w_sum4[SUM4_W-1]};
    assign w_biased = w_sum4 + w_bias;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_avg) begin
            r_avg  <= w_biased[SUM4_W-1:2];
            r_diff <= ERR_W'(r_rf) - ERR_W'(r_lf);
            r_td1  <= r_td;
            r_tt1  <= r_tt;
        end
    end

    assign w_turn_full = SUM4_W'(r_diff) - SUM4_W'(r_tt1);

    always_comb begin
        if (w_turn_full[SUM4_W-1] != w_turn_full[SUM4_W-2]) begin
            w_turn_sat = {w_turn_full[SUM4_W-1], {(ERR_W-1){~w_turn_full[SUM4_W-1]}}};
        end else begin
            w_turn_sat = w_turn_full[ERR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_err) begin
            r_lat_err  <= ERR_W'(r_avg) - ERR_W'(r_td1);
            r_turn_err <= w_turn_sat;
        end
    end

    assign o_lat_err  = r_lat_err;
    assign o_turn_err = r_turn_err;

endmodule

// ===== design/ddpid_loop.sv =====
// ============================================================================
// Differential drive dual PID loop
// Holds the previous error and the saturating error sum of one loop, and
// forms the weighted sum of the proportional, integral and derivative terms.
// ============================================================================
`include "differential_drive_dual_pid_core_defines.svh"

module ddpid_loop import ddpid_pkg::*; #(
    parameter int ERR_W     = 25,
    parameter int SUM_WIDTH = 40,
    parameter int ACC_W     = 58
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_pipe_ctl               i_ctl,
    input  logic signed [ERR_W-1:0] i_err,
    input  t_gains                  i_gains,
    output logic signed [ACC_W-1:0] o_acc
);

    localparam int DER_W = ERR_W + 1;
    localparam int ADD_W = (SUM_WIDTH > ERR_W ? SUM_WIDTH : ERR_W) + 1;
    localparam logic signed [ADD_W-1:0] SUM_MAX = (ADD_W'(1) <<< (SUM_WIDTH - 1)) - 1;
    localparam logic signed [ADD_W-1:0] SUM_MIN = -SUM_MAX - 1;

    logic signed [ERR_W-1:0]     r_last;
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic signed [ERR_W-1:0]     r_e;
    logic signed [DER_W-1:0]     r_d;
    logic signed [SUM_WIDTH-1:0] r_s;

    logic signed [ERR_W+GAIN_W-1:0]     r_pe;
    logic signed [DER_W+GAIN_W-1:0]     r_pd;
    logic signed [SUM_WIDTH+GAIN_W-1:0] r_ps;
    logic signed [ACC_W-1:0]            r_acc;

    logic signed [DER_W-1:0]     w_deriv;
    logic signed [ADD_W-1:0]     w_sum_ext;
    logic signed [SUM_WIDTH-1:0] w_sum_sat;

    assign w_deriv   = DER_W'(i_err) - DER_W'(r_last);
    assign w_sum_ext = ADD_W'(r_sum) + ADD_W'(i_err);

    always_comb begin
        if (w_sum_ext > SUM_MAX) begin
            w_sum_sat = SUM_MAX[SUM_WIDTH-1:0];
        end else if (w_sum_ext < SUM_MIN) begin
            w_sum_sat = SUM_MIN[SUM_WIDTH-1:0];
        end else begin
            w_sum_sat = w_sum_ext[SUM_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_sum  <= '0;
        end else if (i_ctl.ld_state) begin
            r_last <= i_err;
            r_sum  <= w_sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_state) begin
            r_e <= i_err;
            r_d <= w_deriv;
            r_s <= w_sum_sat;
        end
        if (i_ctl.ld_prod) begin
            r_pe <= r_e * $signed(i_gains.kp);
            r_pd <= r_d * $signed(i_gains.kd);
            r_ps <= r_s * $signed(i_gains.ki);
        end
        if (i_ctl.ld_acc) begin
            r_acc <= ACC_W'(r_pe) + ACC_W'(r_pd) + ACC_W'(r_ps);
        end
    end

    assign o_acc = r_acc;

    // A positive error never lowers the running sum.
    `DDPID_ASSERT_NEXT(a_sum_rises, i_clk, i_rst_n, i_ctl.ld_state && (i_err > 0), r_sum >= $past(r_sum))

endmodule

// ===== design/ddpid_mix.sv =====
// ============================================================================
// Differential drive dual PID output mixer
// Combines the two loop sums into right and left power, scales them to
// whole percent with truncation toward zero and clamps them to the range.
// ============================================================================
`include "differential_drive_dual_pid_core_defines.svh"

module ddpid_mix import ddpid_pkg::*; #(
    parameter int ACC_W          = 58,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_pipe_ctl                 i_ctl,
    input  logic signed [ACC_W-1:0]   i_lat_acc,
    input  logic signed [ACC_W-1:0]   i_turn_acc,
    output logic signed [DRIVE_W-1:0] o_right_drive,
    output logic signed [DRIVE_W-1:0] o_left_drive
);

    localparam int MIX_W = ACC_W + 1;
    localparam logic [MIX_W-1:0] LIMIT = MIX_W'(DRIVE_MAX * DIV_CONST) << GAIN_FRAC_BITS;
    localparam int QUOT_LSB = GAIN_FRAC_BITS + DIV_POW2_BITS;

    logic signed [MIX_W-1:0]   r_mix   [NUM_LANES];
    logic                      r_neg   [NUM_LANES];
    logic                      r_clamp [NUM_LANES];
    logic [QUOT_W-1:0]         r_quot  [NUM_LANES];
    logic signed [DRIVE_W-1:0] r_drive [NUM_LANES];

    logic [MIX_W-1:0]        w_mag   [NUM_LANES];
    logic [RECIP_PROD_W-1:0] w_prod  [NUM_LANES];
    logic [DRIVE_W-1:0]      w_q     [NUM_LANES];
    logic signed [DRIVE_W-1:0] w_drive [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mix) begin
            r_mix[LANE_RIGHT] <= MIX_W'(i_lat_acc) + MIX_W'(i_turn_acc);
            r_mix[LANE_LEFT]  <= MIX_W'(i_lat_acc) - MIX_W'(i_turn_acc);
        end
    end

    // The magnitude is shifted by the power-of-two part of the divisor; the
    // remaining division by three uses a reciprocal that is exact below 512.
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            w_mag[i]   = r_mix[i][MIX_W-1] ? MIX_W'(-r_mix[i]) : MIX_W'(r_mix[i]);
            w_prod[i]  = RECIP_PROD_W'(r_quot[i]) * RECIP_PROD_W'(RECIP_MUL);
            w_q[i]     = r_clamp[i] ? DRIVE_W'(DRIVE_MAX) : w_prod[i][RECIP_SHIFT +: DRIVE_W];
            w_drive[i] = r_neg[i] ? -w_q[i] : w_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_LANES; i++) begin
            if (i_ctl.ld_mag) begin
                r_neg[i]   <= r_mix[i][MIX_W-1];
                r_clamp[i] <= (w_mag[i] >= LIMIT);
                r_quot[i]  <= w_mag[i][QUOT_LSB +: QUOT_W];
            end
            if (i_ctl.ld_out) begin
                r_drive[i] <= w_drive[i];
            end
        end
    end

    assign o_right_drive = r_drive[LANE_RIGHT];
    assign o_left_drive  = r_drive[LANE_LEFT];

    `DDPID_ASSERT(a_right_range, i_clk, i_rst_n, $past(i_ctl.ld_out), (o_right_drive >= -DRIVE_MAX) && (o_right_drive <= DRIVE_MAX))
    `DDPID_ASSERT(a_left_range, i_clk, i_rst_n, $past(i_ctl.ld_out), (o_left_drive >= -DRIVE_MAX) && (o_left_drive <= DRIVE_MAX))
    `DDPID_ASSERT_NEXT(a_right_clamp, i_clk, i_rst_n, i_ctl.ld_out && r_clamp[LANE_RIGHT], (o_right_drive == DRIVE_MAX) || (o_right_drive == -DRIVE_MAX))

endmodule

// ===== design/differential_drive_dual_pid_core.sv =====
// ============================================================================
// Differential drive dual PID core
// Throughput: one transaction per cycle through a nine-stage pipeline while the
// output is not stalled; the recurrence on the previous error and the error sum
// closes within one stage.
// Reset: synchronous, active low; clears the gains, both loop states and all valids.
// ============================================================================
`include "differential_drive_dual_pid_core_defines.svh"

module differential_drive_dual_pid_core import ddpid_pkg::*; #(
    parameter int POS_WIDTH      = 24,
    parameter int SUM_WIDTH      = 40,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [IDX_W-1:0]            i_cfg_index,
    input  logic [GAIN_W-1:0]           i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [POS_WIDTH-1:0] i_right_front_pos,
    input  logic signed [POS_WIDTH-1:0] i_left_front_pos,
    input  logic signed [POS_WIDTH-1:0] i_left_back_pos,
    input  logic signed [POS_WIDTH-1:0] i_right_back_pos,
    input  logic signed [POS_WIDTH-1:0] i_target_distance,
    input  logic signed [POS_WIDTH-1:0] i_target_turn,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [DRIVE_W-1:0]   o_right_drive,
    output logic signed [DRIVE_W-1:0]   o_left_drive
);

    localparam int ERR_W  = POS_WIDTH + 1;
    localparam int PROD_W = (SUM_WIDTH > ERR_W + 1 ? SUM_WIDTH : ERR_W + 1) + GAIN_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam int ST_IN    = 0;
    localparam int ST_AVG   = 1;
    localparam int ST_ERR   = 2;
    localparam int ST_STATE = 3;
    localparam int ST_PROD  = 4;
    localparam int ST_ACC   = 5;
    localparam int ST_MIX   = 6;
    localparam int ST_MAG   = 7;
    localparam int ST_OUT   = 8;

    t_gains r_lat_gains, r_turn_gains;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_take, w_vin, w_ld;
    t_pipe_ctl             w_ctl;

    logic signed [ERR_W-1:0] w_lat_err, w_turn_err;
    logic signed [ACC_W-1:0] w_lat_acc, w_turn_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_gains  <= '0;
            r_turn_gains <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_LAT_P:  r_lat_gains.kp  <= i_cfg_wdata;
                REG_LAT_I:  r_lat_gains.ki  <= i_cfg_wdata;
                REG_LAT_D:  r_lat_gains.kd  <= i_cfg_wdata;
                REG_TURN_P: r_turn_gains.kp <= i_cfg_wdata;
                REG_TURN_I: r_turn_gains.ki <= i_cfg_wdata;
                REG_TURN_D: r_turn_gains.kd <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // A stage takes a new transaction when it is empty or its content moves on.
    always_comb begin
        w_take[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_take[k] = !r_vld[k] || w_take[k+1];
        end
    end

    assign w_vin = {r_vld[NUM_STAGES-2:0], i_valid};
    assign w_ld  = w_take & w_vin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (r_vld & ~w_take) | w_ld;
        end
    end

    always_comb begin
        w_ctl.ld_in    = w_ld[ST_IN];
        w_ctl.ld_avg   = w_ld[ST_AVG];
        w_ctl.ld_err   = w_ld[ST_ERR];
        w_ctl.ld_state = w_ld[ST_STATE];
        w_ctl.ld_prod  = w_ld[ST_PROD];
        w_ctl.ld_acc   = w_ld[ST_ACC];
        w_ctl.ld_mix   = w_ld[ST_MIX];
        w_ctl.ld_mag   = w_ld[ST_MAG];
        w_ctl.ld_out   = w_ld[ST_OUT];
    end

    assign o_stall = !w_take[ST_IN];
    assign o_valid = r_vld[ST_OUT];

    ddpid_err #(
        .POS_WIDTH (POS_WIDTH)
    ) u_err (
        .i_clk             (i_clk),
        .i_ctl             (w_ctl),
        .i_right_front_pos (i_right_front_pos),
        .i_left_front_pos  (i_left_front_pos),
        .i_left_back_pos   (i_left_back_pos),
        .i_right_back_pos  (i_right_back_pos),
        .i_target_distance (i_target_distance),
        .i_target_turn     (i_target_turn),
        .o_lat_err         (w_lat_err),
        .o_turn_err        (w_turn_err)
    );

    ddpid_loop #(
        .ERR_W     (ERR_W),
        .SUM_WIDTH (SUM_WIDTH),
        .ACC_W     (ACC_W)
    ) u_lat_loop (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_err   (w_lat_err),
        .i_gains (r_lat_gains),
        .o_acc   (w_lat_acc)
    );

    ddpid_loop #(
        .ERR_W     (ERR_W),
        .SUM_WIDTH (SUM_WIDTH),
        .ACC_W     (ACC_W)
    ) u_turn_loop (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_err   (w_turn_err),
        .i_gains (r_turn_gains),
        .o_acc   (w_turn_acc)
    );

    ddpid_mix #(
        .ACC_W          (ACC_W),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mix (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_lat_acc     (w_lat_acc),
        .i_turn_acc    (w_turn_acc),
        .o_right_drive (o_right_drive),
        .o_left_drive  (o_left_drive)
    );

    // Input stalls only when every stage is full and the result is blocked.
    `DDPID_ASSERT(a_stall_full, i_clk, i_rst_n, o_stall, o_valid && i_stall && (&r_vld))
    `DDPID_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, i_valid && !o_stall, r_vld[ST_IN])

endmodule

// ===== bench/testbench.sv =====
// ============================================================================
// Differential drive dual PID core testbench
// Feeds encoder transactions through the core under random and directed
// traffic, predicts both drive powers with an independent model of the two
// PID loops, and compares every result transaction in order.
// ============================================================================
module testbench;
    import ddpid_pkg::*;

    localparam int POS_W            = 24;
    localparam int SUM_W            = 40;
    localparam int FRAC_BITS        = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 16;
    localparam int RANDOM_PHASES    = 6;
    localparam int PHASE_FRAMES     = 215;
    localparam int WINDUP_FRAMES    = 40;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [IDX_W-1:0] SPARE_IDX_LO = 3'd6;
    localparam logic [IDX_W-1:0] SPARE_IDX_HI = 3'd7;

    localparam t_gains GAINS_TOP     = {3{16'h7FFF}};
    localparam t_gains GAINS_BOTTOM  = {3{16'h8000}};
    localparam t_gains GAINS_LAT_MID = {16'h0100, 16'h0001, 16'h0080};
    localparam t_gains GAINS_TRN_MID = {16'h0080, 16'h0002, 16'h0040};
    localparam t_gains GAINS_WINDUP  = {16'h0000, 16'h0001, 16'h0000};

    typedef struct packed {
        logic signed [POS_W-1:0] rf;
        logic signed [POS_W-1:0] lf;
        logic signed [POS_W-1:0] lb;
        logic signed [POS_W-1:0] rb;
        logic signed [POS_W-1:0] td;
        logic signed [POS_W-1:0] tt;
    } encoder_frame_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] right_pwr;
        logic signed [DRIVE_W-1:0] left_pwr;
    } drive_power_t;

    localparam int FRAME_W    = $bits(encoder_frame_t);
    localparam int GAIN_SET_W = $bits(t_gains);

    logic                      i_clk             = 1'b0;
    logic                      i_rst_n           = 1'b0;
    logic                      i_cfg_wr_en       = 1'b0;
    logic [IDX_W-1:0]          i_cfg_index       = '0;
    logic [GAIN_W-1:0]         i_cfg_wdata       = '0;
    logic                      i_valid           = 1'b0;
    logic                      o_stall;
    logic signed [POS_W-1:0]   i_right_front_pos = '0;
    logic signed [POS_W-1:0]   i_left_front_pos  = '0;
    logic signed [POS_W-1:0]   i_left_back_pos   = '0;
    logic signed [POS_W-1:0]   i_right_back_pos  = '0;
    logic signed [POS_W-1:0]   i_target_distance = '0;
    logic signed [POS_W-1:0]   i_target_turn     = '0;
    logic                      o_valid;
    logic                      i_stall           = 1'b0;
    logic signed [DRIVE_W-1:0] o_right_drive;
    logic signed [DRIVE_W-1:0] o_left_drive;

    differential_drive_dual_pid_core #(
        .POS_WIDTH      (POS_W),
        .SUM_WIDTH      (SUM_W),
        .GAIN_FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_right_front_pos (i_right_front_pos),
        .i_left_front_pos  (i_left_front_pos),
        .i_left_back_pos   (i_left_back_pos),
        .i_right_back_pos  (i_right_back_pos),
        .i_target_distance (i_target_distance),
        .i_target_turn     (i_target_turn),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_right_drive     (o_right_drive),
        .o_left_drive      (o_left_drive)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    encoder_frame_t encoder_frames_q[$];
    drive_power_t   expected_power_q[$];
    int             mismatch_count = 0;
    bit             frame_taken    = 1'b0;
    bit             idle_on        = 1'b1;
    bit             long_hold_req  = 1'b0;
    int             send_gap       = 0;
    int             hold_left      = 0;
    int             walk_pos[4]    = '{0, 0, 0, 0};
    int             walk_goal      = 0;
    int             walk_twist     = 0;

    t_gains                  lat_gains    = '0;
    t_gains                  turn_gains   = '0;
    logic signed [POS_W:0]   lat_prev_err = '0;
    logic signed [POS_W:0]   turn_prev_err = '0;
    logic signed [SUM_W-1:0] lat_err_sum  = '0;
    logic signed [SUM_W-1:0] turn_err_sum = '0;

    function automatic longint clip_to(input longint x, input int w);
        longint top;
        longint bottom;
        top    = (longint'(1) <<< (w - 1)) - 1;
        bottom = -top - 1;
        if (x > top) return top;
        if (x < bottom) return bottom;
        return x;
    endfunction

    function automatic longint loop_term(input longint err, input longint deriv,
                                         input longint total, input t_gains g);
        return err * longint'(g.kp) + deriv * longint'(g.kd) + total * longint'(g.ki);
    endfunction

    function automatic logic signed [DRIVE_W-1:0] to_power(input longint acc);
        longint pct;
        pct = acc / (longint'(DIV_CONST) <<< FRAC_BITS);
        if (pct > DRIVE_MAX) begin
            pct = DRIVE_MAX;
        end else if (pct < -DRIVE_MAX) begin
            pct = -DRIVE_MAX;
        end
        return pct[DRIVE_W-1:0];
    endfunction

    // The error sums are updated before the loop outputs are formed.
    function automatic drive_power_t advance_drive_loops(input encoder_frame_t f);
        longint avg;
        longint lat_err;
        longint turn_err;
        longint lat_total;
        longint turn_total;
        longint lat_acc;
        longint turn_acc;
        drive_power_t p;
        avg        = (longint'(f.rf) + longint'(f.lf) + longint'(f.lb) + longint'(f.rb)) / 4;
        lat_err    = clip_to(avg - longint'(f.td), POS_W + 1);
        turn_err   = clip_to(longint'(f.rf) - longint'(f.lf) - longint'(f.tt), POS_W + 1);
        lat_total  = clip_to(longint'(lat_err_sum) + lat_err, SUM_W);
        turn_total = clip_to(longint'(turn_err_sum) + turn_err, SUM_W);
        lat_acc    = loop_term(lat_err, lat_err - longint'(lat_prev_err), lat_total,
                               lat_gains);
        turn_acc   = loop_term(turn_err, turn_err - longint'(turn_prev_err), turn_total,
                               turn_gains);
        p.right_pwr   = to_power(lat_acc + turn_acc);
        p.left_pwr    = to_power(lat_acc - turn_acc);
        lat_prev_err  = lat_err[POS_W:0];
        turn_prev_err = turn_err[POS_W:0];
        lat_err_sum   = lat_total[SUM_W-1:0];
        turn_err_sum  = turn_total[SUM_W-1:0];
        return p;
    endfunction

    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        frame_taken = 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            frame_taken = 1'b1;
            expected_power_q.push_back(advance_drive_loops(encoder_frames_q.pop_front()));
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (frame_taken || !i_valid)) begin
            if (send_gap > 0) begin
                i_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (encoder_frames_q.size() > 0) begin
                i_valid           <= 1'b1;
                i_right_front_pos <= encoder_frames_q[0].rf;
                i_left_front_pos  <= encoder_frames_q[0].lf;
                i_left_back_pos   <= encoder_frames_q[0].lb;
                i_right_back_pos  <= encoder_frames_q[0].rb;
                i_target_distance <= encoder_frames_q[0].td;
                i_target_turn     <= encoder_frames_q[0].tt;
                send_gap <= (idle_on && $urandom_range(0, 99) < 40) ? pick_idle_len() : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            i_stall   <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES - 1;
        end else if (i_rst_n && idle_on && $urandom_range(0, 99) < 25) begin
            i_stall   <= 1'b1;
            hold_left <= pick_idle_len() - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic report_power(input string field, input int want, input int got);
        mismatch_count++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        drive_power_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_power_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with nothing expected: actual right %0d left %0d",
                         $time, o_right_drive, o_left_drive);
            end else begin
                want = expected_power_q.pop_front();
                if (o_right_drive !== want.right_pwr) begin
                    report_power("right_drive", want.right_pwr, o_right_drive);
                end
                if (o_left_drive !== want.left_pwr) begin
                    report_power("left_drive", want.left_pwr, o_left_drive);
                end
            end
        end
    end

    task automatic queue_frame(input logic signed [POS_W-1:0] rf,
                               input logic signed [POS_W-1:0] lf,
                               input logic signed [POS_W-1:0] lb,
                               input logic signed [POS_W-1:0] rb,
                               input logic signed [POS_W-1:0] td,
                               input logic signed [POS_W-1:0] tt);
        encoder_frame_t f;
        f.rf = rf;
        f.lf = lf;
        f.lb = lb;
        f.rb = rb;
        f.td = td;
        f.tt = tt;
        encoder_frames_q.push_back(f);
    endtask

    task automatic write_gain(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (t_reg_idx'(idx))
            REG_LAT_P:  lat_gains.kp  = val;
            REG_LAT_I:  lat_gains.ki  = val;
            REG_LAT_D:  lat_gains.kd  = val;
            REG_TURN_P: turn_gains.kp = val;
            REG_TURN_I: turn_gains.ki = val;
            REG_TURN_D: turn_gains.kd = val;
            default: ;
        endcase
    endtask

    task automatic program_gains(input t_gains lat, input t_gains turn);
        write_gain(REG_LAT_P, lat.kp);
        write_gain(REG_LAT_I, lat.ki);
        write_gain(REG_LAT_D, lat.kd);
        write_gain(REG_TURN_P, turn.kp);
        write_gain(REG_TURN_I, turn.ki);
        write_gain(REG_TURN_D, turn.kd);
    endtask

    task automatic drain_pipeline();
        while (encoder_frames_q.size() != 0 || expected_power_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_gains small_gains(input bit with_integral);
        t_gains g;
        int kp;
        int ki;
        int kd;
        kp = int'($urandom_range(0, 1024)) - 512;
        ki = with_integral ? int'($urandom_range(0, 8)) - 4 : 0;
        kd = int'($urandom_range(0, 1024)) - 512;
        g.kp = kp[GAIN_W-1:0];
        g.ki = ki[GAIN_W-1:0];
        g.kd = kd[GAIN_W-1:0];
        return g;
    endfunction

    function automatic logic signed [POS_W-1:0] corner_value();
        case ($urandom_range(0, 3))
            0:       return POS_MAX;
            1:       return POS_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // Most frames follow a wheel trajectory that settles toward a moving goal;
    // the rest are random noise or corner values.
    task automatic queue_random_frames(input int count, input int noise_pct);
        encoder_frame_t f;
        int r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < noise_pct) begin
                f = encoder_frame_t'(FRAME_W'({$urandom, $urandom, $urandom, $urandom,
                                               $urandom}));
            end else if (r < noise_pct + 3) begin
                f.rf = corner_value();
                f.lf = corner_value();
                f.lb = corner_value();
                f.rb = corner_value();
                f.td = corner_value();
                f.tt = corner_value();
            end else begin
                if ($urandom_range(0, 99) < 4) begin
                    walk_goal  = int'($urandom_range(0, 40000)) - 20000;
                    walk_twist = int'($urandom_range(0, 1000)) - 500;
                end
                for (int w = 0; w < 4; w++) begin
                    walk_pos[w] += (walk_goal - walk_pos[w]) / 8
                                   + int'($urandom_range(0, 64)) - 32;
                end
                f.rf = POS_W'(walk_pos[0]);
                f.lf = POS_W'(walk_pos[1]);
                f.lb = POS_W'(walk_pos[2]);
                f.rb = POS_W'(walk_pos[3]);
                f.td = POS_W'(walk_goal);
                f.tt = POS_W'(walk_twist);
            end
            encoder_frames_q.push_back(f);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // With the gains at their reset value both powers must be zero.
        queue_frame(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MAX);
        drain_pipeline();

        program_gains(GAINS_LAT_MID, GAINS_TRN_MID);
        queue_frame('0, '0, '0, '0, '0, '0);
        queue_frame(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
        queue_frame(POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN);
        queue_frame(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MIN, '0);
        queue_frame(POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MAX, '0);
        queue_frame(POS_MAX, POS_MIN, '0, '0, '0, POS_MIN);
        queue_frame(POS_MIN, POS_MAX, '0, '0, '0, POS_MAX);
        queue_frame(-24'sd7, '0, '0, '0, '0, '0);
        queue_frame(24'sd7, '0, '0, '0, '0, '0);
        queue_frame(24'sd40, 24'sd30, 24'sd20, 24'sd10, 24'sd20, 24'sd5);
        queue_frame(24'sh555555, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA,
                    24'sh555555, 24'shAAAAAA);
        queue_frame(24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 24'sh555555,
                    24'shAAAAAA, 24'sh555555);
        queue_frame('0, '0, '0, '0, '0, '0);
        drain_pipeline();

        // Writes to indexes past the last register must leave the gains alone.
        write_gain(SPARE_IDX_LO, 16'h7FFF);
        write_gain(SPARE_IDX_HI, 16'h8000);
        queue_frame(24'sd40, 24'sd30, 24'sd20, 24'sd10, 24'sd20, 24'sd5);
        queue_frame(24'sd300, -24'sd200, 24'sd150, 24'sd90, 24'sd50, -24'sd30);
        drain_pipeline();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                1:       program_gains(GAINS_TOP, GAINS_TOP);
                2:       program_gains(GAINS_BOTTOM, GAINS_BOTTOM);
                4:       program_gains(t_gains'(GAIN_SET_W'({$urandom, $urandom})),
                                       t_gains'(GAIN_SET_W'({$urandom, $urandom})));
                default: program_gains(small_gains(ph == 3), small_gains(ph == 3));
            endcase
            idle_on = (ph != 3);
            queue_random_frames(PHASE_FRAMES, (ph == 0 || ph == 5) ? 8 : 25);
            if (ph == 1) begin
                long_hold_req = 1'b1;
            end
            drain_pipeline();
        end

        // A large lateral error and the most negative turn error push the two
        // error sums quickly in opposite directions.
        program_gains(GAINS_WINDUP, GAINS_WINDUP);
        idle_on = 1'b0;
        repeat (WINDUP_FRAMES) begin
            queue_frame(POS_MIN, POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MAX);
        end
        drain_pipeline();

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== differential_drive_dual_pid_core.f =====
+incdir+design
design/ddpid_pkg.sv
design/ddpid_err.sv
design/ddpid_loop.sv
design/ddpid_mix.sv
design/differential_drive_dual_pid_core.sv
bench/testbench.sv
